@@ rtl/core/mss_pkg.sv @@
// Shared types, constants and the segment lookup for the seven-segment scanner.
// No dependencies; compile first.
`default_nettype none

package mss_pkg;

    localparam int TIME_DEPTH   = 10;
    localparam int STATUS_DEPTH = 2;
    localparam int CODE_W       = 7;
    localparam int SEG_W        = 8;
    localparam int COL_W        = 3;
    localparam int NUM_COLS     = 1 << COL_W;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [SEG_W-1:0]  seg_t;
    typedef logic [COL_W-1:0]  col_t;

    typedef enum logic [1:0] {
        OP_WRITE_TIME   = 2'd0,
        OP_WRITE_STATUS = 2'd1,
        OP_TICK         = 2'd2
    } op_t;

    localparam code_t TIME_RESET_CODE   = 7'h30;
    localparam code_t STATUS_RESET_CODE = 7'h5f;
    localparam code_t BLANK_CODE        = 7'h00;

    // Active-low patterns, bit order habcdefg
    localparam seg_t SEG_TABLE [64] = '{
        8'hff, 8'h88, 8'h70, 8'hb1, 8'hc2, 8'hb0, 8'hb8, 8'ha1,
        8'he8, 8'hcf, 8'hc3, 8'hf8, 8'hf1, 8'h89, 8'hea, 8'he2,
        8'h98, 8'h8c, 8'hfa, 8'h92, 8'hf0, 8'he3, 8'hd8, 8'hc1,
        8'hc8, 8'hc4, 8'h92, 8'hb1, 8'hec, 8'h87, 8'h9d, 8'hf7,
        8'hff, 8'hff, 8'hdd, 8'h9c, 8'ha4, 8'h98, 8'h82, 8'hfd,
        8'hb1, 8'h87, 8'h9c, 8'hce, 8'hfb, 8'hfe, 8'hf7, 8'hba,
        8'h81, 8'hcf, 8'h92, 8'h86, 8'hcc, 8'ha4, 8'ha0, 8'h8f,
        8'h80, 8'h84, 8'hff, 8'hbb, 8'hce, 8'hf6, 8'hf8, 8'h9a
    };

    // Map a stored code to its drive pattern; dot clears the h bit before cathode inversion
    function automatic seg_t seg_pattern(input code_t code, input logic anode_drive);
        seg_t pat;
        pat = SEG_TABLE[code[5:0]];
        if (code[6])
        begin
            pat[SEG_W-1] = 1'b0;
        end
        if (!anode_drive)
        begin
            pat = ~pat;
        end
        return pat;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mss_if.sv @@
// Valid/ready channel interfaces for scanner requests and scan results.
// Standalone; no package dependency.
`default_nettype none

interface mss_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [3:0] digit_index;
    logic [7:0] digit_code;

    modport source (output valid, output operation, output digit_index,
                    output digit_code, input ready);
    modport sink   (input valid, input operation, input digit_index,
                    input digit_code, output ready);
endinterface

interface mss_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] column_select;
    logic [7:0] segments_main;
    logic [7:0] segments_aux;

    modport source (output valid, output column_select, output segments_main,
                    output segments_aux, input ready);
    modport sink   (input valid, input column_select, input segments_main,
                    input segments_aux, output ready);
endinterface

`default_nettype wire

@@ rtl/core/multiplexed_seven_segment_scanner.sv @@
// Seven-segment scanner: one item per cycle unless a tick waits on a full result register.
// An input register feeds the store update and segment lookup; writes keep
// draining while a result waits, a tick holds until the result register frees.
// Reset (rst_n low, asynchronous): time digits 0x30, status digits 0x5f,
// scan column 0, common-anode polarity 1, both stages empty.
// Depends on mss_pkg and mss_if.
`default_nettype none

module multiplexed_seven_segment_scanner (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_data,
    mss_req_if.sink    request,
    mss_res_if.source  result
);
    import mss_pkg::*;

    logic        ca_reg;

    logic        s1_valid_reg;
    logic [1:0]  s1_op_reg;
    logic [3:0]  s1_idx_reg;
    code_t       s1_code_reg;

    code_t       time_reg [TIME_DEPTH];
    code_t       status_reg [STATUS_DEPTH];
    col_t        col_reg;

    logic        out_valid_reg;
    seg_t        sel_reg;
    seg_t        main_reg;
    seg_t        aux_reg;

    logic        out_free;
    logic        s1_is_tick;
    logic        s1_advance;
    logic        tick_fire;
    col_t        col_next;
    code_t       aux_code;
    seg_t        sel_next;

    assign out_free   = !out_valid_reg || result.ready;
    assign s1_is_tick = (s1_op_reg == OP_TICK);
    // Writes never need the result register, so they drain regardless
    assign s1_advance = s1_valid_reg && (!s1_is_tick || out_free);
    assign tick_fire  = s1_valid_reg && s1_is_tick && out_free;
    assign request.ready = !s1_valid_reg || s1_advance;

    assign col_next = col_reg + col_t'(1);

    always_comb
    begin
        sel_next = seg_t'(1) << col_next;
        if (!ca_reg)
        begin
            sel_next = ~sel_next;
        end
    end

    always_comb
    begin
        case (col_next)
            3'd0:    aux_code = status_reg[1];
            3'd1:    aux_code = status_reg[0];
            3'd6:    aux_code = time_reg[8];
            3'd7:    aux_code = time_reg[9];
            default: aux_code = BLANK_CODE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            ca_reg <= cfg_data;
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            s1_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            s1_op_reg   <= request.operation;
            s1_idx_reg  <= request.digit_index;
            s1_code_reg <= request.digit_code[CODE_W-1:0];
        end
    end

    // Digit stores and scan column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TIME_DEPTH; i++)
            begin
                time_reg[i] <= TIME_RESET_CODE;
            end
            for (int i = 0; i < STATUS_DEPTH; i++)
            begin
                status_reg[i] <= STATUS_RESET_CODE;
            end
            col_reg <= '0;
        end
        else if (s1_advance)
        begin
            case (s1_op_reg)
                OP_WRITE_TIME:
                begin
                    // drop out-of-range indexes
                    if (s1_idx_reg < 4'(TIME_DEPTH))
                    begin
                        time_reg[s1_idx_reg] <= s1_code_reg;
                    end
                end
                OP_WRITE_STATUS:
                begin
                    if (s1_idx_reg < 4'(STATUS_DEPTH))
                    begin
                        status_reg[s1_idx_reg[0]] <= s1_code_reg;
                    end
                end
                OP_TICK:
                begin
                    col_reg <= col_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= tick_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            sel_reg  <= sel_next;
            main_reg <= seg_pattern(time_reg[{1'b0, col_next}], ca_reg);
            aux_reg  <= seg_pattern(aux_code, ca_reg);
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.column_select = sel_reg;
    assign result.segments_main = main_reg;
    assign result.segments_aux  = aux_reg;

    // A result only appears after a tick sat in the input stage
    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_is_tick))
        else $error("result without a tick item");

    // Column select stays one-hot for a common-anode display
    a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && ca_reg && $past(ca_reg)) |-> $onehot(result.column_select))
        else $error("column select not one-hot");

    // Column moves only when a tick executes
    a_column_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_fire |=> $stable(col_reg))
        else $error("scan column moved without a tick");

endmodule

`default_nettype wire

@@ tb/scan_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the seven-segment scanner: tracks digit stores, scan column and
// polarity from the observed items and compares every scan result as it leaves.
// Depends on mss_pkg and the mss_req_if / mss_res_if channel interfaces.

module scan_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_data,
    mss_req_if   request,
    mss_res_if   result,
    output int   failures,
    output int   outstanding,
    output int   scans_checked
);
    import mss_pkg::*;

    typedef struct packed {
        seg_t column_select;
        seg_t segments_main;
        seg_t segments_aux;
    } scan_frame_t;

    // Active-low glyphs, habcdefg
    localparam seg_t GLYPHS [64] = '{
        8'hff, 8'h88, 8'h70, 8'hb1, 8'hc2, 8'hb0, 8'hb8, 8'ha1,
        8'he8, 8'hcf, 8'hc3, 8'hf8, 8'hf1, 8'h89, 8'hea, 8'he2,
        8'h98, 8'h8c, 8'hfa, 8'h92, 8'hf0, 8'he3, 8'hd8, 8'hc1,
        8'hc8, 8'hc4, 8'h92, 8'hb1, 8'hec, 8'h87, 8'h9d, 8'hf7,
        8'hff, 8'hff, 8'hdd, 8'h9c, 8'ha4, 8'h98, 8'h82, 8'hfd,
        8'hb1, 8'h87, 8'h9c, 8'hce, 8'hfb, 8'hfe, 8'hf7, 8'hba,
        8'h81, 8'hcf, 8'h92, 8'h86, 8'hcc, 8'ha4, 8'ha0, 8'h8f,
        8'h80, 8'h84, 8'hff, 8'hbb, 8'hce, 8'hf6, 8'hf8, 8'h9a
    };

    code_t       time_digits [TIME_DEPTH];
    code_t       status_digits [STATUS_DEPTH];
    col_t        column;
    logic        anode;
    scan_frame_t scans_due [$];
    int          n_fail;
    int          n_checked;

    function automatic seg_t glyph_drive(input code_t code, input logic anode_mode);
        seg_t pat;
        pat = GLYPHS[code[5:0]];
        if (code[6])
        begin
            pat[7] = 1'b0;
        end
        return anode_mode ? pat : ~pat;
    endfunction

    task automatic check_field(input string name, input seg_t want, input seg_t got);
        if (want !== got)
        begin
            n_fail++;
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scan_frame_t got;
        scan_frame_t want;
        code_t       aux;
        if (!rst_n)
        begin
            foreach (time_digits[i])
            begin
                time_digits[i] = 7'h30;
            end
            foreach (status_digits[i])
            begin
                status_digits[i] = 7'h5f;
            end
            column = '0;
            anode = 1'b1;
            scans_due.delete();
            n_fail = 0;
            n_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                anode = cfg_data;
            end

            if (result.valid && result.ready)
            begin
                got = '{result.column_select, result.segments_main, result.segments_aux};
                if (scans_due.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: unexpected scan result, expected none, got %06h",
                             $time, got);
                end
                else
                begin
                    want = scans_due.pop_front();
                    check_field("column_select", want.column_select, got.column_select);
                    check_field("segments_main", want.segments_main, got.segments_main);
                    check_field("segments_aux", want.segments_aux, got.segments_aux);
                    n_checked++;
                end
            end

            if (request.valid && request.ready)
            begin
                case (request.operation)
                    OP_WRITE_TIME:
                    begin
                        if (request.digit_index < TIME_DEPTH)
                        begin
                            time_digits[request.digit_index] = request.digit_code[6:0];
                        end
                    end
                    OP_WRITE_STATUS:
                    begin
                        if (request.digit_index < STATUS_DEPTH)
                        begin
                            status_digits[request.digit_index] = request.digit_code[6:0];
                        end
                    end
                    OP_TICK:
                    begin
                        // Advance first, then show the new column
                        column = column + 1'b1;
                        if (column < 2)
                        begin
                            aux = status_digits[1 - column];
                        end
                        else if (column == 6)
                        begin
                            aux = time_digits[8];
                        end
                        else if (column == 7)
                        begin
                            aux = time_digits[9];
                        end
                        else
                        begin
                            aux = BLANK_CODE;
                        end
                        want.column_select = anode ? (8'd1 << column) : ~(8'd1 << column);
                        want.segments_main = glyph_drive(time_digits[column], anode);
                        want.segments_aux = glyph_drive(aux, anode);
                        scans_due.push_back(want);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        failures <= n_fail;
        scans_checked <= n_checked;
        outstanding <= scans_due.size();
    end

endmodule

@@ tb/tb_multiplexed_seven_segment_scanner.sv @@
`timescale 1ns / 1ps
// Top of the scanner testbench: clock, reset, request and result traffic, and verdict.
// Depends on mss_pkg, the channel interfaces, scan_checker and the scanner RTL.

module tb_multiplexed_seven_segment_scanner;
    import mss_pkg::*;

    localparam int         RESET_CYCLES    = 12;
    localparam int         SETTLE_CYCLES   = 4;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         SINK_HOLD       = 150;
    localparam int         RANDOM_PHASES   = 6;
    localparam int         ITEMS_PER_PHASE = 200;
    localparam logic [1:0] OP_UNUSED       = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;
    logic hold_start;
    logic hold_done;
    int   failures;
    int   outstanding;
    int   scans_checked;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   ticks_sent = 0;
    int   polarity_writes = 0;

    mss_req_if request_ch ();
    mss_res_if result_ch ();

    multiplexed_seven_segment_scanner i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .request  (request_ch),
        .result   (result_ch)
    );

    scan_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .request       (request_ch),
        .result        (result_ch),
        .failures      (failures),
        .outstanding   (outstanding),
        .scans_checked (scans_checked)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results pending",
                     cycle_count, outstanding);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 98)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Result side: bursts of ready, random stalls, one long hold-off on request
    initial
    begin
        int run;
        int gap;
        result_ch.ready <= 1'b0;
        hold_done <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_start && !hold_done)
            begin
                result_ch.ready <= 1'b0;
                repeat (SINK_HOLD) @(posedge clk);
                hold_done <= 1'b1;
            end
            else
            begin
                run = $urandom_range(1, 40);
                result_ch.ready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [3:0] idx,
                             input logic [7:0] code, input int gap);
        request_ch.valid <= 1'b1;
        request_ch.operation <= op;
        request_ch.digit_index <= idx;
        request_ch.digit_code <= code;
        @(posedge clk);
        while (!request_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (op == OP_TICK)
        begin
            ticks_sent++;
        end
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_tick(input int gap);
        send_item(OP_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), gap);
    endtask

    // Drop valid, wait for every scan result, then let the pipeline settle
    task automatic wait_for_idle();
        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_polarity(input logic anode_drive);
        wait_for_idle();
        cfg_we <= 1'b1;
        cfg_data <= anode_drive;
        @(posedge clk);
        cfg_we <= 1'b0;
        polarity_writes++;
    endtask

    task automatic send_random(input bit no_gaps);
        int         r;
        logic [1:0] op;
        logic [3:0] idx;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            op = OP_TICK;
            idx = 4'($urandom_range(0, 15));
        end
        else if (r < 75)
        begin
            op = OP_WRITE_TIME;
            idx = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, TIME_DEPTH - 1))
                                             : 4'($urandom_range(TIME_DEPTH, 15));
        end
        else if (r < 95)
        begin
            op = OP_WRITE_STATUS;
            idx = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, STATUS_DEPTH - 1))
                                             : 4'($urandom_range(STATUS_DEPTH, 15));
        end
        else
        begin
            op = OP_UNUSED;
            idx = 4'($urandom_range(0, 15));
        end
        send_item(op, idx, 8'($urandom_range(0, 255)), no_gaps ? 0 : pick_gap());
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= 1'b0;
        hold_start <= 1'b0;
        request_ch.valid <= 1'b0;
        request_ch.operation <= OP_WRITE_TIME;
        request_ch.digit_index <= '0;
        request_ch.digit_code <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset contents on the first columns
        repeat (3) send_tick(pick_gap());
        // Code extremes, dropped bit 7, out-of-range indexes, unused operation
        send_item(OP_WRITE_TIME, 4'd0, 8'hff, pick_gap());
        send_item(OP_WRITE_TIME, 4'd9, 8'h00, pick_gap());
        send_item(OP_WRITE_TIME, 4'd8, 8'h40, pick_gap());
        send_item(OP_WRITE_TIME, 4'd7, 8'h80, pick_gap());
        send_item(OP_WRITE_STATUS, 4'd0, 8'h3f, pick_gap());
        send_item(OP_WRITE_STATUS, 4'd1, 8'hc1, pick_gap());
        send_item(OP_WRITE_TIME, 4'd10, 8'h12, pick_gap());
        send_item(OP_WRITE_TIME, 4'd15, 8'hff, pick_gap());
        send_item(OP_WRITE_STATUS, 4'd2, 8'h55, pick_gap());
        send_item(OP_WRITE_STATUS, 4'd15, 8'haa, pick_gap());
        send_item(OP_UNUSED, 4'd0, 8'h5a, pick_gap());
        // Full sweep including the wrap back to column 0
        repeat (8) send_tick(pick_gap());
        set_polarity(1'b0);
        repeat (3) send_tick(pick_gap());

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_polarity(ph % 2 == 0);
            if (ph == 2)
            begin
                // Keep offering ticks through the result-side hold-off
                hold_start <= 1'b1;
                while (!hold_done)
                begin
                    send_tick(0);
                end
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_random(ph == 0);
            end
        end
        wait_for_idle();

        $display("Sent %0d items (%0d scan ticks) over %0d polarity writes;",
                 items_sent, ticks_sent, polarity_writes);
        $display("compared %0d scan results field by field, %0d mismatches.",
                 scans_checked, failures);
        if (failures == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
